// File: src/iso_ts_pkg.sv
// shared types, codes and constants for the timestamp to epoch converter
`timescale 1ns / 1ps
package iso_ts_pkg;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_LEN   = 3'd1,
		ST_DIGIT = 3'd2,
		ST_SEP   = 3'd3,
		ST_SIGN  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_MON,
		BK_ERA,
		BK_YOE,
		BK_MUL,
		BK_DOE,
		BK_DAYS,
		BK_SECP,
		BK_SECS,
		BK_MS,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		status_t     status;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [9:0]  millis;
		logic [6:0]  zone_h;
		logic [6:0]  zone_m;
		logic        zone_neg;
	} ts_rec_t;

	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [4:0] LEN_PLAIN   = 5'd19;
	localparam logic [4:0] LEN_ZULU    = 5'd20;
	localparam logic [4:0] LEN_MS      = 5'd23;
	localparam logic [4:0] LEN_MS_ZULU = 5'd24;
	localparam logic [4:0] LEN_ZONE    = 5'd25;
	localparam logic [4:0] LEN_MS_ZONE = 5'd29;
	localparam logic [4:0] POS_MAX     = 5'd31;

	localparam int TAIL_LEN = 10;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic [3:0] dig(input logic [7:0] c);
		return 4'(c - CH_0);
	endfunction

	// days from march 1 to the first of the shifted month
	function automatic logic [8:0] doy_of(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// File: src/iso_ts_if.sv
// valid/ready channel interfaces for characters in and epoch results out
`timescale 1ns / 1ps
interface iso_ts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last;
	modport source (output valid, char_code, last, input ready);
	modport sink (input valid, char_code, last, output ready);
endinterface

interface iso_ts_out_if;
	logic               valid;
	logic               ready;
	logic signed [49:0] epoch_ms;
	logic [2:0]         status;
	modport source (output valid, epoch_ms, status, input ready);
	modport sink (input valid, epoch_ms, status, output ready);
endinterface

// File: src/iso8601_fixed_timestamp_to_epoch.sv
// top level: iso 8601 fixed-form timestamp to utc epoch milliseconds
// The block takes one character per cycle on in_ch and answers each string on the
// item flagged last with one result on out_ch: epoch milliseconds and a status.
// The parser front end never stalls by itself; it stops only when the two-entry
// queue of parsed strings is full. The back end converts one string at a time
// (a step sequencer of short multiplies) and takes the next only after handing
// the result into the output register, so strings of every valid form stream at
// one character per cycle while out_ch is ready. Results stay in order.
`timescale 1ns / 1ps
module iso8601_fixed_timestamp_to_epoch
	import iso_ts_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	iso_ts_in_if.sink     in_ch,
	iso_ts_out_if.source  out_ch
);

	logic    push, full, pop, empty;
	ts_rec_t push_rec, head;

	iso_ts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.full     (full),
		.push     (push),
		.push_rec (push_rec)
	);

	iso_ts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	iso_ts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status != ST_OK) |-> out_ch.epoch_ms == '0)
		else $error("nonzero epoch on error");

endmodule

// File: src/iso_ts_front.sv
// front end: character parser, separator checks and digit field gathering
`timescale 1ns / 1ps
module iso_ts_front
	import iso_ts_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	iso_ts_in_if.sink    in_ch,
	input  logic         full,
	output logic         push,
	output ts_rec_t      push_rec
);

	logic [4:0]  pos_q, pos_n;
	logic [13:0] year_q, year_n;
	logic [6:0]  month_q, month_n, day_q, day_n, hour_q, hour_n;
	logic [6:0]  minute_q, minute_n, second_q, second_n;
	status_t     err_q, err_n;
	logic [7:0]  tail_q [TAIL_LEN];
	logic [7:0]  tail_n [TAIL_LEN];
	logic        accept;

	logic [7:0]  c;
	logic [3:0]  d;
	logic        isd;
	logic [4:0]  len;
	logic        len_ok, has_ms, has_zulu, has_zone;
	logic [7:0]  zc [6];
	logic [7:0]  zulu_c;
	status_t     tst;
	logic [9:0]  millis;
	logic [6:0]  zh, zm;
	logic        zneg;

	assign in_ch.ready = !full;
	assign accept = in_ch.valid && !full;
	assign push = accept && in_ch.last;

	always_comb begin
		pos_n = pos_q;
		year_n = year_q;
		month_n = month_q;
		day_n = day_q;
		hour_n = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		err_n = err_q;
		for (int i = 0; i < TAIL_LEN; i++) tail_n[i] = tail_q[i];
		c = in_ch.char_code;
		d = dig(c);
		isd = is_dig(c);
		if (accept) begin
			pos_n = (pos_q == POS_MAX) ? POS_MAX : 5'(pos_q + 5'd1);
			if (pos_q < LEN_PLAIN) begin
				if (pos_q == 5'd4 || pos_q == 5'd7) begin
					if (c != CH_DASH && err_q == ST_OK) err_n = ST_SEP;
				end else if (pos_q == 5'd10) begin
					if (c != CH_T && err_q == ST_OK) err_n = ST_SEP;
				end else if (pos_q == 5'd13 || pos_q == 5'd16) begin
					if (c != CH_COLON && err_q == ST_OK) err_n = ST_SEP;
				end else if (!isd) begin
					if (err_q == ST_OK) err_n = ST_DIGIT;
				end else if (pos_q < 5'd4) begin
					year_n = 14'(year_q * 10 + d);
				end else if (pos_q < 5'd7) begin
					month_n = 7'(month_q * 10 + d);
				end else if (pos_q < 5'd10) begin
					day_n = 7'(day_q * 10 + d);
				end else if (pos_q < 5'd13) begin
					hour_n = 7'(hour_q * 10 + d);
				end else if (pos_q < 5'd16) begin
					minute_n = 7'(minute_q * 10 + d);
				end else begin
					second_n = 7'(second_q * 10 + d);
				end
			end else if (pos_q < LEN_MS_ZONE) begin
				tail_n[4'(pos_q - LEN_PLAIN)] = c;
			end
		end
	end

	// tail check on the completed string
	always_comb begin
		len = pos_n;
		len_ok = len == LEN_PLAIN || len == LEN_ZULU || len == LEN_MS ||
			len == LEN_MS_ZULU || len == LEN_ZONE || len == LEN_MS_ZONE;
		has_ms = len == LEN_MS || len == LEN_MS_ZULU || len == LEN_MS_ZONE;
		has_zulu = len == LEN_ZULU || len == LEN_MS_ZULU;
		has_zone = len == LEN_ZONE || len == LEN_MS_ZONE;
		for (int i = 0; i < 6; i++) begin
			zc[i] = (len == LEN_MS_ZONE) ? tail_n[i + 4] : tail_n[i];
		end
		zulu_c = (len == LEN_MS_ZULU) ? tail_n[4] : tail_n[0];
		tst = ST_OK;
		millis = '0;
		zh = '0;
		zm = '0;
		zneg = 1'b0;
		if (has_ms) begin
			if (tail_n[0] != CH_DOT && tail_n[0] != CH_COMMA) begin
				tst = ST_SEP;
			end else if (!is_dig(tail_n[1]) || !is_dig(tail_n[2]) || !is_dig(tail_n[3])) begin
				tst = ST_DIGIT;
			end else begin
				millis = 10'(dig(tail_n[1]) * 100 + dig(tail_n[2]) * 10 + dig(tail_n[3]));
			end
		end
		if (tst == ST_OK && has_zulu && zulu_c != CH_Z) tst = ST_SEP;
		if (tst == ST_OK && has_zone) begin
			if (zc[0] == CH_PLUS) zneg = 1'b0;
			else if (zc[0] == CH_DASH) zneg = 1'b1;
			else tst = ST_SIGN;
			if (tst == ST_OK) begin
				if (!is_dig(zc[1]) || !is_dig(zc[2])) tst = ST_DIGIT;
				else if (zc[3] != CH_COLON) tst = ST_SEP;
				else if (!is_dig(zc[4]) || !is_dig(zc[5])) tst = ST_DIGIT;
			end
			zh = 7'(dig(zc[1]) * 10 + dig(zc[2]));
			zm = 7'(dig(zc[4]) * 10 + dig(zc[5]));
		end
	end

	always_comb begin
		push_rec.status = !len_ok ? ST_LEN : (err_n != ST_OK) ? err_n : tst;
		push_rec.year = year_n;
		push_rec.month = month_n;
		push_rec.day = day_n;
		push_rec.hour = hour_n;
		push_rec.minute = minute_n;
		push_rec.second = second_n;
		push_rec.millis = millis;
		push_rec.zone_h = zh;
		push_rec.zone_m = zm;
		push_rec.zone_neg = zneg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			year_q <= '0;
			month_q <= '0;
			day_q <= '0;
			hour_q <= '0;
			minute_q <= '0;
			second_q <= '0;
			err_q <= ST_OK;
			for (int i = 0; i < TAIL_LEN; i++) tail_q[i] <= '0;
		end else if (push) begin
			pos_q <= '0;
			year_q <= '0;
			month_q <= '0;
			day_q <= '0;
			hour_q <= '0;
			minute_q <= '0;
			second_q <= '0;
			err_q <= ST_OK;
			for (int i = 0; i < TAIL_LEN; i++) tail_q[i] <= '0;
		end else begin
			pos_q <= pos_n;
			year_q <= year_n;
			month_q <= month_n;
			day_q <= day_n;
			hour_q <= hour_n;
			minute_q <= minute_n;
			second_q <= second_n;
			err_q <= err_n;
			for (int i = 0; i < TAIL_LEN; i++) tail_q[i] <= tail_n[i];
		end
	end

endmodule

// File: src/iso_ts_queue.sv
// two-entry queue of parsed timestamps between front and back
`timescale 1ns / 1ps
module iso_ts_queue
	import iso_ts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  ts_rec_t push_rec,
	output logic    full,
	input  logic    pop,
	output ts_rec_t head,
	output logic    empty
);

	ts_rec_t    ent_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			if (push && !pop) cnt_q <= 2'(cnt_q + 2'd1);
			else if (pop && !push) cnt_q <= 2'(cnt_q - 2'd1);
		end
	end

endmodule

// File: src/iso_ts_back.sv
// back end: stepwise civil date to epoch millisecond conversion
`timescale 1ns / 1ps
module iso_ts_back
	import iso_ts_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         empty,
	input  ts_rec_t      head,
	output logic         pop,
	iso_ts_out_if.source out_ch
);

	bk_state_t state_q, state_n;
	logic      load;

	ts_rec_t            rec_q;
	logic [13:0]        yy_q;
	logic [3:0]         mp_q;
	logic [4:0]         era_q;
	logic [8:0]         yoe_q;
	logic [8:0]         doy_q;
	logic [17:0]        p365_q;
	logic [1:0]         c100_q;
	logic [17:0]        doe_q;
	logic [21:0]        eday_q;
	logic signed [23:0] days_q;
	logic signed [40:0] dsec_q;
	logic [18:0]        hsec_q;
	logic [12:0]        msec_q;
	logic signed [41:0] secs_q;
	logic signed [51:0] msprod_q;
	logic [28:0]        off_q;

	logic               out_valid_q;
	logic signed [49:0] epoch_q;
	status_t            status_q;

	logic [6:0]  mv;
	logic [3:0]  mq;
	logic [3:0]  mr;
	logic [12:0] mprod;
	logic [29:0] eprod;
	logic [17:0] cprod;
	logic [49:0] res;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BK_IDLE: if (!empty) state_n = BK_MON;
			BK_MON:  state_n = BK_ERA;
			BK_ERA:  state_n = BK_YOE;
			BK_YOE:  state_n = BK_MUL;
			BK_MUL:  state_n = BK_DOE;
			BK_DOE:  state_n = BK_DAYS;
			BK_DAYS: state_n = BK_SECP;
			BK_SECP: state_n = BK_SECS;
			BK_SECS: state_n = BK_MS;
			BK_MS:   state_n = BK_DONE;
			BK_DONE: if (!out_valid_q || out_ch.ready) state_n = BK_IDLE;
			default: state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == BK_IDLE) && !empty;
		load = (state_q == BK_DONE) && (!out_valid_q || out_ch.ready);
	end

	always_comb begin
		mv = 7'(rec_q.month - 7'd1);
		mprod = 13'(mv * 6'd43);
		mq = 4'(mprod >> 9);
		mr = 4'(mv - 7'(mq * 4'd12));
		eprod = 30'(yy_q * 16'd41944);
		cprod = 18'(yoe_q * 10'd656);
		res = 50'(msprod_q) + 50'(rec_q.millis) +
			(rec_q.zone_neg ? 50'(off_q) : 50'(-50'(off_q)));
	end

	always_ff @(posedge clk) begin
		if (pop) rec_q <= head;
		if (state_q == BK_MON) begin
			if (rec_q.month == 7'd0) begin
				yy_q <= 14'(rec_q.year + 14'd399);
				mp_q <= 4'd9;
			end else begin
				yy_q <= 14'(rec_q.year + mq + 14'd400 - ((mr <= 4'd1) ? 14'd1 : 14'd0));
				mp_q <= (mr >= 4'd2) ? 4'(mr - 4'd2) : 4'(mr + 4'd10);
			end
		end
		if (state_q == BK_ERA) era_q <= 5'(eprod >> 24);
		if (state_q == BK_YOE) begin
			yoe_q <= 9'(yy_q - 14'(era_q * 9'd400));
			doy_q <= doy_of(mp_q);
		end
		if (state_q == BK_MUL) begin
			p365_q <= 18'(yoe_q * 9'd365);
			c100_q <= 2'(cprod >> 16);
		end
		if (state_q == BK_DOE) begin
			doe_q <= 18'(p365_q + (yoe_q >> 2) - c100_q + doy_q);
			eday_q <= 22'(era_q * 18'd146097);
		end
		if (state_q == BK_DAYS) begin
			days_q <= 24'(eday_q) + 24'(doe_q) + 24'(rec_q.day) - 24'(865566);
		end
		if (state_q == BK_SECP) begin
			dsec_q <= 41'(days_q) * 41'(17'd86400);
			hsec_q <= 19'(rec_q.hour * 12'd3600);
			msec_q <= 13'(rec_q.minute * 6'd60);
		end
		if (state_q == BK_SECS) begin
			secs_q <= 42'(dsec_q) + 42'(hsec_q) + 42'(msec_q) + 42'(rec_q.second);
		end
		if (state_q == BK_MS) begin
			msprod_q <= 52'(secs_q) * 52'(10'd1000);
			off_q <= 29'(rec_q.zone_h * 22'd3600000) + 29'(rec_q.zone_m * 16'd60000);
		end
		if (load) begin
			epoch_q <= (rec_q.status == ST_OK) ? $signed(res) : '0;
			status_q <= rec_q.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.epoch_ms = epoch_q;
	assign out_ch.status = status_q;

endmodule
